// ===== hw/rtl/tss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants of the transient / sustain splitter.
// ----------------------------------------------------------------------------
package tss_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_FAST_COEF = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_COEF = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEPARATION = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MONO_INPUT = 2'd3;

    // Register widths and reset values
    localparam int COEF_W = 24;
    localparam int SEP_W  = 17;

    localparam logic [COEF_W-1:0] FAST_COEF_RESET = 24'd345904;
    localparam logic [COEF_W-1:0] SLOW_COEF_RESET = 24'd8736;
    localparam logic [SEP_W-1:0]  SEPARATION_RESET = 17'd32768;

    // Envelope, gain and divider widths
    localparam int ENV_W     = 32;
    localparam int GAIN_FRAC = 16;
    localparam int GAIN_W    = 17;
    localparam int SENS_W    = 20;
    localparam int PROD_W    = ENV_W + SENS_W;
    localparam int DEN_W     = 53;
    localparam int REM_W     = 54;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'h10000;
    localparam logic [SENS_W-1:0] SENS_BASE  = 20'h20000;
    localparam logic [DEN_W-1:0]  DEN_BASE   = 53'h0800000000000;

    // Scale operand codes
    localparam logic [1:0] SC_TRANS_L = 2'd0;
    localparam logic [1:0] SC_TRANS_R = 2'd1;
    localparam logic [1:0] SC_SUST_L  = 2'd2;
    localparam logic [1:0] SC_SUST_R  = 2'd3;

    typedef struct packed {
        logic [COEF_W-1:0] fast_coef;
        logic [COEF_W-1:0] slow_coef;
        logic [SEP_W-1:0]  separation;
        logic              mono;
    } t_cfg;

    typedef struct packed {
        logic       capture;
        logic       detect;
        logic       env_mul;
        logic       env_slow;
        logic       env_upd;
        logic       onset;
        logic       product;
        logic       div_step;
        logic       scale_mul;
        logic [1:0] scale_idx;
        logic       scale_wr;
        logic       load_out;
    } t_cmd;

endpackage
`default_nettype wire

// ===== hw/rtl/tss_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tss_cfg_regs
// Configuration register file, written through a valid/ready port.
// ----------------------------------------------------------------------------
module tss_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tss_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [tss_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output tss_pkg::t_cfg                        o_cfg
);
    import tss_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_coef  <= FAST_COEF_RESET;
            r_cfg.slow_coef  <= SLOW_COEF_RESET;
            r_cfg.separation <= SEPARATION_RESET;
            r_cfg.mono       <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FAST_COEF:  r_cfg.fast_coef  <= i_cfg_data[COEF_W-1:0];
                CFG_SLOW_COEF:  r_cfg.slow_coef  <= i_cfg_data[COEF_W-1:0];
                CFG_SEPARATION: r_cfg.separation <= i_cfg_data[SEP_W-1:0];
                CFG_MONO_INPUT: r_cfg.mono       <= i_cfg_data[0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tss_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer: steps one sample through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module tss_ctrl (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  wire logic  i_out_stall,
    output tss_pkg::t_cmd o_cmd
);
    import tss_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DETECT,
        S_MUL_FAST,
        S_UPD_FAST,
        S_MUL_SLOW,
        S_UPD_SLOW,
        S_ONSET,
        S_PRODUCT,
        S_DIVIDE,
        S_SCALE,
        S_DONE
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DETECT;
                end
            end
            S_DETECT: begin
                o_cmd.detect = 1'b1;
                n_state      = S_MUL_FAST;
            end
            S_MUL_FAST: begin
                o_cmd.env_mul = 1'b1;
                n_state       = S_UPD_FAST;
            end
            S_UPD_FAST: begin
                o_cmd.env_upd = 1'b1;
                n_state       = S_MUL_SLOW;
            end
            S_MUL_SLOW: begin
                o_cmd.env_mul  = 1'b1;
                o_cmd.env_slow = 1'b1;
                n_state        = S_UPD_SLOW;
            end
            S_UPD_SLOW: begin
                o_cmd.env_upd  = 1'b1;
                o_cmd.env_slow = 1'b1;
                n_state        = S_ONSET;
            end
            S_ONSET: begin
                o_cmd.onset = 1'b1;
                n_state     = S_PRODUCT;
            end
            S_PRODUCT: begin
                o_cmd.product = 1'b1;
                n_cnt         = '0;
                n_state       = S_DIVIDE;
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_cnt   = '0;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                // multiply operand cnt, write back operand cnt-1
                o_cmd.scale_mul = (r_cnt != 4'd4);
                o_cmd.scale_idx = r_cnt[1:0];
                o_cmd.scale_wr  = (r_cnt != 4'd0);
                n_cnt           = r_cnt + 4'd1;
                if (r_cnt == 4'd4) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is empty or draining
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tss_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tss_datapath
// Detector, envelope followers, gain divider, sample scaler, output register.
// ----------------------------------------------------------------------------
module tss_datapath #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEFF_BITS  = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tss_pkg::t_cmd                 i_cmd,
    input  wire tss_pkg::t_cfg                 i_cfg,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right_sample,
    input  wire logic                          i_last_in_block,
    output logic signed [SAMPLE_BITS-1:0]      o_transient_left,
    output logic signed [SAMPLE_BITS-1:0]      o_transient_right,
    output logic signed [SAMPLE_BITS-1:0]      o_sustain_left,
    output logic signed [SAMPLE_BITS-1:0]      o_sustain_right,
    output logic [tss_pkg::GAIN_W-1:0]         o_transient_gain,
    output logic                               o_block_end
);
    import tss_pkg::*;

    // usable coefficient bits
    localparam int CW      = (COEFF_BITS < COEF_W) ? COEFF_BITS : COEF_W;
    localparam int EPROD_W = CW + ENV_W;
    localparam int SPROD_W = SAMPLE_BITS + GAIN_W + 1;
    localparam int SRES_W  = SPROD_W - GAIN_FRAC;
    localparam logic signed [SRES_W-1:0] SMP_MAX =
        SRES_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SRES_W-1:0] SMP_MIN =
        SRES_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [SPROD_W-1:0] ROUND_HALF =
        SPROD_W'(64'sd1 <<< (GAIN_FRAC - 1));

    // working registers
    logic signed [SAMPLE_BITS-1:0] r_left, r_right;
    logic                          r_last;
    logic [ENV_W-1:0]              r_x;
    logic [ENV_W-1:0]              r_fast_env, r_slow_env;
    logic [EPROD_W-1:0]            r_eprod;
    logic                          r_up;
    logic [ENV_W-1:0]              r_onset;
    logic [SENS_W-1:0]             r_sens;
    logic [REM_W-1:0]              r_rem;
    logic [DEN_W-1:0]              r_den;
    logic [GAIN_FRAC-1:0]          r_gain;
    logic signed [SPROD_W-1:0]     r_sprod;
    logic [1:0]                    r_sidx;
    logic signed [SAMPLE_BITS-1:0] r_tl, r_tr, r_sl, r_sr;

    // detector
    logic signed [SAMPLE_BITS:0] sum;
    logic [SAMPLE_BITS:0]        sum_abs;
    logic [SAMPLE_BITS-1:0]      mag;

    always_comb begin
        sum     = (SAMPLE_BITS+1)'(r_left) + (SAMPLE_BITS+1)'(r_right);
        sum_abs = sum[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-sum) : sum;
        mag     = sum_abs[SAMPLE_BITS:1];
    end

    // envelope follower
    logic [COEF_W-1:0] coef;
    logic [ENV_W-1:0]  env_cur, env_diff, env_step, env_next;
    logic              env_up;

    always_comb begin
        coef     = i_cmd.env_slow ? i_cfg.slow_coef : i_cfg.fast_coef;
        env_cur  = i_cmd.env_slow ? r_slow_env : r_fast_env;
        env_up   = (r_x >= env_cur);
        env_diff = env_up ? (r_x - env_cur) : (env_cur - r_x);
        env_step = ENV_W'(r_eprod >> COEFF_BITS);
        env_next = r_up ? (env_cur + env_step) : (env_cur - env_step);
    end

    // sensitivity = 2 + 12 * min(separation, 1)
    logic [SEP_W-1:0]  sep_c;
    logic [SENS_W-1:0] sens;

    always_comb begin
        sep_c = i_cfg.separation[SEP_W-1] ? GAIN_UNITY : i_cfg.separation;
        sens  = SENS_BASE + (SENS_W'(sep_c) << 3) + (SENS_W'(sep_c) << 2);
    end

    // product and restoring divide step
    logic [PROD_W-1:0] prod_p;
    logic [REM_W-1:0]  rem_sh;
    logic              div_bit;

    always_comb begin
        prod_p  = PROD_W'(r_onset) * PROD_W'(r_sens);
        rem_sh  = r_rem << 1;
        div_bit = (rem_sh >= REM_W'(r_den));
    end

    // sample scaler: one shared multiplier, four operands
    logic signed [SAMPLE_BITS-1:0] sc_smp;
    logic [GAIN_W-1:0]             sc_gain;
    logic signed [SPROD_W-1:0]     sc_prod;
    logic signed [SRES_W-1:0]      sc_res;
    logic signed [SAMPLE_BITS-1:0] sc_sat;

    always_comb begin
        case (i_cmd.scale_idx)
            SC_TRANS_L: begin
                sc_smp  = r_left;
                sc_gain = GAIN_W'(r_gain);
            end
            SC_TRANS_R: begin
                sc_smp  = r_right;
                sc_gain = GAIN_W'(r_gain);
            end
            SC_SUST_L: begin
                sc_smp  = r_left;
                sc_gain = GAIN_UNITY - GAIN_W'(r_gain);
            end
            default: begin
                sc_smp  = r_right;
                sc_gain = GAIN_UNITY - GAIN_W'(r_gain);
            end
        endcase
        sc_prod = SPROD_W'(sc_smp) * $signed({1'b0, sc_gain});
        sc_res  = SRES_W'((r_sprod + ROUND_HALF) >>> GAIN_FRAC);
        if (sc_res > SMP_MAX) begin
            sc_sat = SAMPLE_BITS'(SMP_MAX);
        end else if (sc_res < SMP_MIN) begin
            sc_sat = SAMPLE_BITS'(SMP_MIN);
        end else begin
            sc_sat = SAMPLE_BITS'(sc_res);
        end
    end

    // envelope state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_env <= '0;
            r_slow_env <= '0;
        end else if (i_cmd.env_upd) begin
            if (i_cmd.env_slow) begin
                r_slow_env <= env_next;
            end else begin
                r_fast_env <= env_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_left  <= i_left_sample;
            r_right <= i_cfg.mono ? i_left_sample : i_right_sample;
            r_last  <= i_last_in_block;
        end
        if (i_cmd.detect) begin
            r_x <= ENV_W'(mag) << (ENV_W - SAMPLE_BITS);
        end
        if (i_cmd.env_mul) begin
            r_eprod <= EPROD_W'(coef[CW-1:0]) * EPROD_W'(env_diff);
            r_up    <= env_up;
        end
        if (i_cmd.onset) begin
            r_onset <= (r_fast_env > r_slow_env) ? (r_fast_env - r_slow_env) : '0;
            r_sens  <= sens;
        end
        if (i_cmd.product) begin
            r_rem  <= REM_W'(prod_p);
            r_den  <= DEN_BASE + DEN_W'(prod_p);
            r_gain <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= div_bit ? (rem_sh - REM_W'(r_den)) : rem_sh;
            r_gain <= {r_gain[GAIN_FRAC-2:0], div_bit};
        end
        if (i_cmd.scale_mul) begin
            r_sprod <= sc_prod;
            r_sidx  <= i_cmd.scale_idx;
        end
        if (i_cmd.scale_wr) begin
            case (r_sidx)
                SC_TRANS_L: r_tl <= sc_sat;
                SC_TRANS_R: r_tr <= sc_sat;
                SC_SUST_L:  r_sl <= sc_sat;
                default:    r_sr <= sc_sat;
            endcase
        end
        if (i_cmd.load_out) begin
            o_transient_left  <= r_tl;
            o_transient_right <= r_tr;
            o_sustain_left    <= r_sl;
            o_sustain_right   <= r_sr;
            o_transient_gain  <= GAIN_W'(r_gain);
            o_block_end       <= r_last;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/transient_sustain_splitter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// transient_sustain_splitter_top
// Splits a stereo stream into transient and sustain parts by envelope onset.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one word per stereo sample
//   pair (left, right, block-end mark). A word is taken on a clock edge with
//   i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid / i_out_stall carry one word per input word:
//   left and right times the transient gain g, times 1-g, g, and the mark.
//   Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index
//   selects fast coefficient, slow coefficient, separation or mono flag.
//   Write it only while no sample is in flight.
//   Timing: the input is stalled from each acceptance until the result is
//   loaded into the output register, so a new word is not taken while a
//   sample is in flight. The 16-step gain divider and the single shared
//   scaling multiplier (four products) set the time per sample.
//   A finished word waits in the output register while the next sample is
//   taken and processed; if the receiver is still stalling when that next
//   result is ready, hold it in the datapath until the register drains.
//   Reset: synchronous, active low; clears both envelopes, loads default
//   config, drops any pending output word.
// ----------------------------------------------------------------------------
module transient_sustain_splitter_top #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEFF_BITS  = 24
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // sample input
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_right_sample,
    input  wire logic                            i_last_in_block,
    // result output
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]        o_transient_left,
    output logic signed [SAMPLE_BITS-1:0]        o_transient_right,
    output logic signed [SAMPLE_BITS-1:0]        o_sustain_left,
    output logic signed [SAMPLE_BITS-1:0]        o_sustain_right,
    output logic [tss_pkg::GAIN_W-1:0]           o_transient_gain,
    output logic                                 o_block_end,
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tss_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [tss_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tss_pkg::*;

    t_cfg cfg;
    t_cmd cmd;

    // register file: coefficients, separation, mono flag
    tss_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // sequencer: advance one sample through the datapath, own handshakes
    tss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // arithmetic and output register
    tss_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg             (cfg),
        .i_left_sample     (i_left_sample),
        .i_right_sample    (i_right_sample),
        .i_last_in_block   (i_last_in_block),
        .o_transient_left  (o_transient_left),
        .o_transient_right (o_transient_right),
        .o_sustain_left    (o_sustain_left),
        .o_sustain_right   (o_sustain_right),
        .o_transient_gain  (o_transient_gain),
        .o_block_end       (o_block_end)
    );

endmodule
`default_nettype wire

// ===== test/transient_sustain_splitter_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transient_sustain_splitter_top_test
// Self-checking bench for the transient / sustain splitter. A scoreboard
// class predicts the envelope followers, the onset-to-gain divide and the
// four scaled channel words for every accepted sample pair. Output words
// are checked field by field in order. Stimulus is a short directed set of
// extremes, then drum-like hits with random content under several register
// settings, with random idling and stalling on both channels in all but one phase.
// ----------------------------------------------------------------------------
module transient_sustain_splitter_top_test;
    import tss_pkg::*;

    localparam int SAMPLE_BITS = 24;
    localparam int COEFF_BITS  = 24;
    localparam longint SMP_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SMP_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));
    localparam logic signed [SAMPLE_BITS-1:0] MAXS = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] MINS = 24'sh800000;
    // Quiet time that drain waits after the last owed word.
    localparam int SETTLE_CYCLES = 40;

    // One output word: both channels split by g, g itself and the block mark.
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] trans_l;
        logic signed [SAMPLE_BITS-1:0] trans_r;
        logic signed [SAMPLE_BITS-1:0] sust_l;
        logic signed [SAMPLE_BITS-1:0] sust_r;
        logic [GAIN_W-1:0]             gain;
        logic                          block_end;
    } t_split_word;

    // Tracks the register file and both envelopes, and holds the split words
    // still owed by the block, oldest first.
    class split_board;
        t_split_word       pending_splits[$];
        logic [COEF_W-1:0] fast_coef;
        logic [COEF_W-1:0] slow_coef;
        logic [SEP_W-1:0]  separation;
        logic              mono;
        logic [ENV_W-1:0]  fast_env;
        logic [ENV_W-1:0]  slow_env;
        int                failures;

        function new();
            fast_coef  = FAST_COEF_RESET;
            slow_coef  = SLOW_COEF_RESET;
            separation = SEPARATION_RESET;
            mono       = 1'b0;
            fast_env   = '0;
            slow_env   = '0;
            failures   = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FAST_COEF:  fast_coef  = data[COEF_W-1:0];
                CFG_SLOW_COEF:  slow_coef  = data[COEF_W-1:0];
                CFG_SEPARATION: separation = data[SEP_W-1:0];
                CFG_MONO_INPUT: mono       = data[0];
                default: ;
            endcase
        endfunction

        // Move the envelope toward x by coef * distance, truncated.
        function logic [ENV_W-1:0] follow_env(logic [ENV_W-1:0] env, logic [ENV_W-1:0] x,
                                              logic [COEF_W-1:0] coef);
            logic [63:0] step;
            if (x >= env) begin
                step = (64'(coef) * 64'(x - env)) >> COEFF_BITS;
                return env + step[ENV_W-1:0];
            end
            step = (64'(coef) * 64'(env - x)) >> COEFF_BITS;
            return env - step[ENV_W-1:0];
        endfunction

        // Sample times a Q1.16 gain, round half up, saturate.
        function logic signed [SAMPLE_BITS-1:0] weigh(longint smp, longint gain);
            longint r;
            r = (smp * gain + 32768) >>> GAIN_FRAC;
            if (r > SMP_MAX) r = SMP_MAX;
            if (r < SMP_MIN) r = SMP_MIN;
            return r[SAMPLE_BITS-1:0];
        endfunction

        function void note_sample(logic signed [SAMPLE_BITS-1:0] l,
                                  logic signed [SAMPLE_BITS-1:0] r, logic last);
            longint           left;
            longint           right;
            longint           sum;
            longint           mag;
            logic [ENV_W-1:0] x;
            logic [63:0]      onset;
            logic [63:0]      sep;
            logic [63:0]      prod;
            logic [63:0]      den;
            logic [63:0]      rem;
            logic [GAIN_W-1:0] g;
            t_split_word      w;
            left  = longint'(l);
            // Mono mode: the left sample stands in for the right one.
            right = mono ? left : longint'(r);
            sum   = left + right;
            mag   = (sum < 0 ? -sum : sum) >> 1;
            x     = ENV_W'(mag << (ENV_W - SAMPLE_BITS));
            fast_env = follow_env(fast_env, x, fast_coef);
            slow_env = follow_env(slow_env, x, slow_coef);
            onset = (fast_env > slow_env) ? 64'(fast_env - slow_env) : 64'd0;
            // Separation above one acts as one.
            sep  = (separation > GAIN_UNITY) ? 64'(GAIN_UNITY) : 64'(separation);
            prod = onset * (64'(SENS_BASE) + 64'd12 * sep);
            den  = 64'(DEN_BASE) + prod;
            rem  = prod;
            g    = '0;
            for (int i = 0; i < GAIN_FRAC; i++) begin
                rem = rem << 1;
                g   = g << 1;
                if (rem >= den) begin
                    rem  = rem - den;
                    g[0] = 1'b1;
                end
            end
            w.trans_l   = weigh(left, longint'(g));
            w.trans_r   = weigh(right, longint'(g));
            w.sust_l    = weigh(left, longint'(GAIN_UNITY - g));
            w.sust_r    = weigh(right, longint'(GAIN_UNITY - g));
            w.gain      = g;
            w.block_end = last;
            pending_splits.push_back(w);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_split(t_split_word got);
            t_split_word want;
            if (pending_splits.size() == 0) begin
                $error("output word with no sample pending");
                failures++;
                return;
            end
            want = pending_splits.pop_front();
            compare_field("transient_left", want.trans_l, got.trans_l);
            compare_field("transient_right", want.trans_r, got.trans_r);
            compare_field("sustain_left", want.sust_l, got.sust_l);
            compare_field("sustain_right", want.sust_r, got.sust_r);
            compare_field("transient_gain", want.gain, got.gain);
            compare_field("block_end", want.block_end, got.block_end);
        endfunction
    endclass

    // Every input starts at a known value.
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic signed [SAMPLE_BITS-1:0] i_left_sample = '0;
    logic signed [SAMPLE_BITS-1:0] i_right_sample = '0;
    logic                          i_last_in_block = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_transient_left;
    logic signed [SAMPLE_BITS-1:0] o_transient_right;
    logic signed [SAMPLE_BITS-1:0] o_sustain_left;
    logic signed [SAMPLE_BITS-1:0] o_sustain_right;
    logic [GAIN_W-1:0]             o_transient_gain;
    logic                          o_block_end;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_INDEX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;

    // When set, neither side idles.
    bit steady = 1'b0;

    split_board board;

    transient_sustain_splitter_top #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COEFF_BITS (COEFF_BITS)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_left_sample    (i_left_sample),
        .i_right_sample   (i_right_sample),
        .i_last_in_block  (i_last_in_block),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_transient_left (o_transient_left),
        .o_transient_right(o_transient_right),
        .o_sustain_left   (o_sustain_left),
        .o_sustain_right  (o_sustain_right),
        .o_transient_gain (o_transient_gain),
        .o_block_end      (o_block_end),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest correct run.
    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: check each word taken at this edge, then pick the stall for
    // the next cycle. Values read here are the ones from before the edge.
    always @(posedge i_clk) begin
        t_split_word got;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got.trans_l   = o_transient_left;
                got.trans_r   = o_transient_right;
                got.sust_l    = o_sustain_left;
                got.sust_r    = o_sustain_right;
                got.gain      = o_transient_gain;
                got.block_end = o_block_end;
                board.check_split(got);
            end
            i_out_stall <= !steady && ($urandom_range(0, 99) < 29);
        end
    end

    // Offer one sample word after a random idle gap, and hold it until taken.
    // Leave valid high on return so back-to-back words keep it up.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] l,
                               input logic signed [SAMPLE_BITS-1:0] r, input logic last);
        while (!steady && $urandom_range(0, 99) < 29) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_left_sample   <= l;
        i_right_sample  <= r;
        i_last_in_block <= last;
        do @(posedge i_clk); while (o_in_stall);
        board.note_sample(l, r, last);
    endtask

    // Drop valid and wait for every owed word, then let the block go quiet.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (board.pending_splits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Hold a register write until the port takes it; valid stays up.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_register(idx, data);
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] fast,
                                 input logic [CFG_DATA_W-1:0] slow,
                                 input logic [CFG_DATA_W-1:0] sep,
                                 input logic [CFG_DATA_W-1:0] mono);
        write_reg(CFG_FAST_COEF, fast);
        write_reg(CFG_SLOW_COEF, slow);
        write_reg(CFG_SEPARATION, sep);
        write_reg(CFG_MONO_INPUT, mono);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] random_level(int amp);
        int v;
        v = $urandom_range(0, amp);
        return ($urandom_range(0, 1) != 0) ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
    endfunction

    // Drum-like hits: a quiet stretch, then a loud onset that decays.
    // About one word in ten is full-width noise that breaks the pattern.
    task automatic play_hits(input int count);
        int sent;
        int quiet_len;
        int hit_len;
        int amp;
        logic signed [SAMPLE_BITS-1:0] l;
        logic signed [SAMPLE_BITS-1:0] r;
        sent = 0;
        while (sent < count) begin
            quiet_len = $urandom_range(0, 24);
            hit_len   = $urandom_range(1, 30);
            amp       = $urandom_range(1 << 12, (1 << (SAMPLE_BITS - 1)) - 1);
            for (int k = 0; k < quiet_len + hit_len && sent < count; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    l = SAMPLE_BITS'($urandom);
                    r = SAMPLE_BITS'($urandom);
                end else if (k < quiet_len) begin
                    l = random_level(255);
                    r = random_level(255);
                end else begin
                    l = random_level(amp);
                    r = random_level(amp);
                    amp = amp * 7 / 8;
                end
                send_sample(l, r, $urandom_range(0, 7) == 0);
                sent++;
            end
        end
    endtask

    initial begin
        board = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes at the reset register values: full-scale, cancelling
        // pairs, odd sums, and a sustained loud run to build an onset.
        send_sample('0, '0, 1'b0);
        send_sample(MAXS, MAXS, 1'b1);
        send_sample(MINS, MINS, 1'b0);
        send_sample(MAXS, MINS, 1'b0);
        send_sample(MINS, MAXS, 1'b1);
        send_sample(24'sd1, -24'sd1, 1'b0);
        send_sample(-24'sd1, -24'sd1, 1'b1);
        send_sample(MINS, MINS, 1'b0);
        send_sample(MINS, MINS, 1'b0);
        send_sample(MINS, MINS, 1'b0);
        send_sample(24'sh555555, 24'shAAAAAA, 1'b1);
        send_sample('0, '0, 1'b0);
        drain();

        // Mono mode with separation above one and an instant fast follower:
        // the right sample must be ignored.
        apply_setting(24'hFFFFFF, 24'h000000, 24'h01FFFF, 24'h000001);
        send_sample(MAXS, MINS, 1'b1);
        send_sample(MINS, '0, 1'b0);
        send_sample('0, MAXS, 1'b0);
        send_sample(MAXS, MAXS, 1'b0);
        send_sample(24'sd1, MINS, 1'b1);
        send_sample(MINS, MINS, 1'b0);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                // Fast tracks at once, slow never moves: largest onsets.
                0: apply_setting(24'hFFFFFF, 24'h000000, 24'd65536, 24'd0);
                // Fast never moves, slow tracks at once; lowest separation.
                1: apply_setting(24'h000000, 24'hFFFFFF, 24'd0, 24'd1);
                // Musical followers; all upper data bits set on separation and mono.
                2: apply_setting(CFG_DATA_W'($urandom_range(1 << 18, 1 << 22)),
                                 CFG_DATA_W'($urandom_range(1 << 10, 1 << 16)),
                                 24'hFFFFFF, 24'hFFFFFE);
                3: apply_setting(CFG_DATA_W'($urandom_range(1 << 18, 1 << 22)),
                                 CFG_DATA_W'($urandom_range(1 << 10, 1 << 16)),
                                 CFG_DATA_W'($urandom_range(0, 24'h1FFFF)), 24'd1);
                4: apply_setting(FAST_COEF_RESET, SLOW_COEF_RESET,
                                 CFG_DATA_W'(SEPARATION_RESET), 24'd0);
                default: apply_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                       CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
            endcase
            // One phase runs with no idling on either side.
            steady = (phase == 2);
            play_hits(210);
            steady = 1'b0;
            drain();
        end

        if (board.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
